// ----- sv/i2c_master_register_access_assert.svh -----
// ----------------------------------------------------------------------------
// I2C register access assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// Same-cycle implication.
`define I2CRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2CRA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/i2cra_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register access package
// Payload types, sequencer segment codes, program tables and sample voting.
// ----------------------------------------------------------------------------
package i2cra_pkg;

    localparam int SAMPLES     = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int ERR_W       = 16;
    localparam int PHASE_W     = 4;
    localparam int SUB_W       = 2;
    localparam int BIT_W       = 4;

    localparam logic [PHASE_W-1:0] RD_LEN = 4'd12;
    localparam logic [PHASE_W-1:0] WR_LEN = 4'd8;
    localparam logic [BIT_W-1:0]   BYTE_BITS = 4'd8;

    localparam logic [7:0] DIR_WR_MASK = 8'hfe;
    localparam logic [7:0] DIR_RD_BIT  = 8'h01;

    // Voting looks only at sample bits that exist in the 8-bit field
    localparam int VOTE_BITS = (SAMPLES < 8) ? SAMPLES : 8;
    localparam int VOTE_MIN  = (SAMPLES + 1) / 2;
    localparam int VOTE_CW   = $clog2(VOTE_BITS + 1);

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    typedef enum logic [3:0] {
        SEG_START,
        SEG_SEND_DW,
        SEG_SEND_DR,
        SEG_SEND_REG,
        SEG_SEND_DATA,
        SEG_ACK,
        SEG_PULSE,
        SEG_RECV,
        SEG_STOP
    } seg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] dev_addr;
        logic [7:0] target_reg;
        logic [7:0] write_data;
        logic [7:0] sda_samples;
    } req_t;

    typedef struct packed {
        logic             scl_level;
        logic             sda_level;
        logic             busy_res;
        logic             done_res;
        logic [7:0]       read_data;
        logic             ack_error;
        logic [ERR_W-1:0] error_count;
    } rsp_t;

    // Segment played at a given program step (steps count from 1)
    function automatic seg_t prog_seg(input logic wr, input logic [PHASE_W-1:0] ph);
        seg_t s;
        s = SEG_STOP;
        if (wr)
        begin
            unique case (ph)
                4'd1:    s = SEG_START;
                4'd2:    s = SEG_SEND_DW;
                4'd3:    s = SEG_ACK;
                4'd4:    s = SEG_SEND_REG;
                4'd5:    s = SEG_ACK;
                4'd6:    s = SEG_SEND_DATA;
                4'd7:    s = SEG_PULSE;
                default: s = SEG_STOP;
            endcase
        end
        else
        begin
            unique case (ph)
                4'd1:    s = SEG_START;
                4'd2:    s = SEG_SEND_DW;
                4'd3:    s = SEG_ACK;
                4'd4:    s = SEG_SEND_REG;
                4'd5:    s = SEG_ACK;
                4'd6:    s = SEG_PULSE;
                4'd7:    s = SEG_START;
                4'd8:    s = SEG_SEND_DR;
                4'd9:    s = SEG_ACK;
                4'd10:   s = SEG_RECV;
                4'd11:   s = SEG_PULSE;
                default: s = SEG_STOP;
            endcase
        end
        return s;
    endfunction

    // Majority vote over the SDA samples of one tick; a tie reads as one
    function automatic logic vote(input logic [7:0] s);
        logic [VOTE_CW-1:0] ones;
        ones = '0;
        for (int i = 0; i < VOTE_BITS; i++)
        begin
            ones = ones + VOTE_CW'(s[i]);
        end
        return (ones >= VOTE_CW'(VOTE_MIN));
    endfunction

endpackage

// ----- sv/i2cra_core.sv -----
// ----------------------------------------------------------------------------
// I2C register access sequencer core
// Holds the bus sequencer state and plays one tick per enabled cycle.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_assert.svh"

module i2cra_core
    import i2cra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t item,
    output rsp_t res
);

    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [SUB_W-1:0]       sub_reg, sub_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [7:0]             shout_reg, shout_next;
    logic [7:0]             shin_reg, shin_next;
    logic                   wr_reg, wr_next;
    logic [7:0]             dev_reg, dev_next;
    logic [7:0]             rega_reg, rega_next;
    logic [7:0]             data_reg, data_next;
    logic                   flag_reg, flag_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   sda_now_reg, sda_now_next;

    logic               start_req;
    logic [PHASE_W-1:0] ph_eff;
    logic [SUB_W-1:0]   sub_eff;
    logic [BIT_W-1:0]   bit_eff;
    logic [BIT_W-1:0]   bit_inc;
    logic [PHASE_W-1:0] len_eff;
    logic               in_prog;
    logic               corrupt;
    logic               seg_end;
    logic               last_seg;
    logic               scl_out;
    logic               sda_out;
    logic [7:0]         byte_sel;
    seg_t               seg;

    // A start request is latched and its first tick played in the same step
    assign start_req = (phase_reg == '0) && ((item.mode == MODE_READ) ||
                                             (item.mode == MODE_WRITE));
    assign ph_eff    = start_req ? PHASE_W'(1) : phase_reg;
    assign sub_eff   = start_req ? '0 : sub_reg;
    assign bit_eff   = start_req ? '0 : bit_reg;
    assign wr_next   = start_req ? (item.mode == MODE_WRITE) : wr_reg;
    assign dev_next  = start_req ? item.dev_addr : dev_reg;
    assign rega_next = start_req ? item.target_reg : rega_reg;
    assign data_next = start_req ? item.write_data : data_reg;
    assign len_eff   = wr_next ? WR_LEN : RD_LEN;
    assign in_prog   = (ph_eff != '0) && (ph_eff <= len_eff);
    assign corrupt   = ph_eff > len_eff;
    assign seg       = prog_seg(wr_next, ph_eff);
    assign bit_inc   = bit_eff + BIT_W'(1);
    assign last_seg  = ph_eff >= len_eff;

    always_comb
    begin
        unique case (seg)
            SEG_SEND_DW:  byte_sel = dev_next & DIR_WR_MASK;
            SEG_SEND_DR:  byte_sel = dev_next | DIR_RD_BIT;
            SEG_SEND_REG: byte_sel = rega_next;
            default:      byte_sel = data_next;
        endcase
    end

    // End of the current segment
    always_comb
    begin
        unique case (seg)
            SEG_START, SEG_ACK:
                seg_end = sub_eff >= SUB_W'(2);
            SEG_SEND_DW, SEG_SEND_DR, SEG_SEND_REG, SEG_SEND_DATA:
                seg_end = (sub_eff >= SUB_W'(2)) && (bit_inc >= BYTE_BITS);
            SEG_RECV:
                seg_end = (sub_eff != '0) && (bit_inc >= BYTE_BITS);
            default:
                seg_end = sub_eff == SUB_W'(3);
        endcase
    end

    // Bus levels for this tick, as (SCL, SDA)
    always_comb
    begin
        scl_out = 1'b1;
        sda_out = 1'b1;
        if (in_prog)
        begin
            sda_out = sda_now_reg;
            unique case (seg)
                SEG_START:
                begin
                    if (sub_eff == 2'd0)
                    begin
                        scl_out = 1'b1;
                        sda_out = 1'b1;
                    end
                    else if (sub_eff == 2'd1)
                    begin
                        scl_out = 1'b1;
                        sda_out = 1'b0;
                    end
                    else
                    begin
                        scl_out = 1'b0;
                        sda_out = 1'b0;
                    end
                end
                SEG_SEND_DW, SEG_SEND_DR, SEG_SEND_REG, SEG_SEND_DATA:
                begin
                    if (sub_eff == 2'd0)
                    begin
                        scl_out = 1'b0;
                    end
                    else if (sub_eff == 2'd1)
                    begin
                        scl_out = 1'b0;
                        sda_out = shout_reg[7];
                    end
                    else
                    begin
                        scl_out = 1'b1;
                    end
                end
                SEG_ACK:
                begin
                    scl_out = sub_eff >= 2'd2;
                    if (sub_eff != 2'd0)
                    begin
                        sda_out = 1'b1;
                    end
                end
                SEG_PULSE:
                begin
                    scl_out = sub_eff == 2'd2;
                    if (sub_eff != 2'd0)
                    begin
                        sda_out = 1'b1;
                    end
                end
                SEG_RECV:
                begin
                    scl_out = sub_eff != 2'd0;
                    sda_out = 1'b1;
                end
                default:
                begin
                    scl_out = sub_eff >= 2'd2;
                    if (sub_eff == 2'd1 || sub_eff == 2'd2)
                    begin
                        sda_out = 1'b0;
                    end
                    else if (sub_eff == 2'd3)
                    begin
                        sda_out = 1'b1;
                    end
                end
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        phase_next   = ph_eff;
        sub_next     = sub_eff;
        bit_next     = bit_eff;
        shout_next   = shout_reg;
        shin_next    = shin_reg;
        flag_next    = flag_reg;
        count_next   = count_reg;
        rx_next      = rx_reg;
        sda_now_next = sda_now_reg;
        if (corrupt)
        begin
            phase_next   = '0;
            sub_next     = '0;
            bit_next     = '0;
            sda_now_next = 1'b1;
        end
        else if (in_prog)
        begin
            sub_next     = sub_eff + SUB_W'(1);
            sda_now_next = sda_out;
            unique case (seg)
                SEG_SEND_DW, SEG_SEND_DR, SEG_SEND_REG, SEG_SEND_DATA:
                begin
                    if (sub_eff == 2'd0)
                    begin
                        if (bit_eff == '0)
                        begin
                            shout_next = byte_sel;
                        end
                    end
                    else if (sub_eff == 2'd1)
                    begin
                        shout_next = {shout_reg[6:0], 1'b0};
                    end
                    else
                    begin
                        bit_next = bit_inc;
                        sub_next = '0;
                    end
                end
                SEG_ACK:
                begin
                    if (sub_eff >= 2'd2 && item.sda_samples[0])
                    begin
                        flag_next = 1'b1;
                        if (count_reg != '1)
                        begin
                            count_next = count_reg + COUNT_WIDTH'(1);
                        end
                    end
                end
                SEG_RECV:
                begin
                    if (sub_eff == 2'd0)
                    begin
                        if (bit_eff == '0)
                        begin
                            shin_next = '0;
                        end
                    end
                    else
                    begin
                        shin_next = {shin_reg[6:0], vote(item.sda_samples)};
                        bit_next  = bit_inc;
                        sub_next  = '0;
                        if (seg_end)
                        begin
                            rx_next = shin_next;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (seg_end)
            begin
                sub_next   = '0;
                bit_next   = '0;
                phase_next = last_seg ? '0 : ph_eff + PHASE_W'(1);
            end
        end
    end

    always_comb
    begin
        res.scl_level   = scl_out;
        res.sda_level   = sda_out;
        res.busy_res    = in_prog;
        res.done_res    = in_prog && seg_end && last_seg;
        res.read_data   = rx_next;
        res.ack_error   = flag_next;
        res.error_count = ERR_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            sub_reg     <= '0;
            bit_reg     <= '0;
            shout_reg   <= '0;
            shin_reg    <= '0;
            wr_reg      <= 1'b0;
            dev_reg     <= '0;
            rega_reg    <= '0;
            data_reg    <= '0;
            flag_reg    <= 1'b0;
            count_reg   <= '0;
            rx_reg      <= '0;
            sda_now_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            sub_reg     <= sub_next;
            bit_reg     <= bit_next;
            shout_reg   <= shout_next;
            shin_reg    <= shin_next;
            wr_reg      <= wr_next;
            dev_reg     <= dev_next;
            rega_reg    <= rega_next;
            data_reg    <= data_next;
            flag_reg    <= flag_next;
            count_reg   <= count_next;
            rx_reg      <= rx_next;
            sda_now_reg <= sda_now_next;
        end
    end

    `I2CRA_ASSERT_NXT(a_flag_sticky, flag_reg, flag_reg, "ack error flag cleared")
    `I2CRA_ASSERT_IMP(a_count_flag, count_reg != '0, flag_reg, "missed count without flag")
    `I2CRA_ASSERT_IMP(a_idle_clean, phase_reg == '0, {sub_reg, bit_reg} == '0, "idle not clean")
    `I2CRA_ASSERT_IMP(a_idle_bus, step && !res.busy_res, res.scl_level && res.sda_level, "bus driven")

endmodule

// ----- sv/i2c_master_register_access.sv -----
// ----------------------------------------------------------------------------
// I2C master register access
// One-byte register read and write sequencer with open-drain bus levels.
// ----------------------------------------------------------------------------
// Every request transaction is one bus delay tick and yields exactly one
// response transaction with the SCL/SDA levels for that tick. A mode of read
// or write while idle latches the device address, register address and data
// byte and starts the sequence on that same tick; mode is ignored while busy.
// Throughput is one tick per clock: the sequencer step is a single pass of
// logic between the request register and the response register, so a new
// request is taken every cycle the response side is not stalled. ack_error
// and error_count are sticky until reset; read_data holds the byte of the
// last read.

module i2c_master_register_access
    import i2cra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_item,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_item
);

    logic in_valid_reg, in_valid_next;
    req_t in_reg;
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg;
    rsp_t step_res;
    logic advance;
    logic load_in;

    // Step the sequencer whenever a held tick can move into the response slot
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign load_in   = req_valid && !req_stall;

    assign in_valid_next  = load_in || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && rsp_stall);

    i2cra_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_reg),
        .res   (step_res)
    );

    // Control: hold valid flags across stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_reg <= req_item;
        end
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule
